// ===== design/laser_vector_shape_generator_core_assert.svh =====
// Assertion macros shared by the design files.
`ifndef LASER_VECTOR_SHAPE_GENERATOR_CORE_ASSERT_SVH
`define LASER_VECTOR_SHAPE_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LVSG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LVSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LVSG_ASSERT(label, clk, rst, prop, msg)
`define LVSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/lvsg_pkg.sv =====
package lvsg_pkg;

   localparam int CIRCLE_SEGMENTS    = 36;
   localparam int TRIG_FRACTION_BITS = 15;
   localparam int TRIG_W             = TRIG_FRACTION_BITS + 2;

   localparam int COORD_W  = 16;
   localparam int DELTA_W  = COORD_W + 1;
   localparam int STEP_W   = 17;
   localparam int DWELL_W  = 14;
   localparam int MSL_W    = 10;
   localparam int DPU_W    = 4;
   localparam int DPU_SQ_W = 2 * DPU_W;
   localparam int VIDX_W   = $clog2(CIRCLE_SEGMENTS + 2);
   localparam int D2_W     = 2 * COORD_W + 1;
   localparam int DPROD_W  = D2_W + DPU_SQ_W;

   localparam int DIV_NUM_W  = 2 * STEP_W;
   localparam int DIV_DEN_W  = STEP_W;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
   localparam int SQRT_IN_W  = DPROD_W + (DPROD_W % 2);
   localparam int SQRT_OUT_W = SQRT_IN_W / 2;
   localparam int SQRT_CNT_W = $clog2(SQRT_OUT_W + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DWELL_W-1:0] DWELL_MAX = {DWELL_W{1'b1}};
   localparam logic [MSL_W-1:0]   MSL_RESET = MSL_W'(100);
   localparam logic [DPU_W-1:0]   DPU_RESET = DPU_W'(2);

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_CIRCLE = 2'd1,
      CMD_RECT   = 2'd2,
      CMD_LINE   = 2'd3
   } cmd_type;

   localparam cmd_type SHAPE_IDLE = CMD_TICK;

   localparam logic REG_MAX_STEP_LENGTH = 1'b0;
   localparam logic REG_DWELL_PER_UNIT  = 1'b1;

   typedef struct packed {
      logic [MSL_W-1:0] max_step;
      logic [DPU_W-1:0] dwell_unit;
   } cfg_type;

   typedef struct packed {
      logic                 is_start;
      cmd_type              cmd;
      logic [COORD_W-1:0]   pos_x;
      logic [COORD_W-1:0]   pos_y;
      logic [COORD_W-1:0]   param_a;
      logic [COORD_W-1:0]   param_b;
   } item_type;

   typedef struct packed {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic               beam_on;
      logic [DWELL_W-1:0] dwell_us;
      logic               shape_done;
   } res_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [SQRT_IN_W-1:0] rad;
   } sqrt_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [SQRT_OUT_W-1:0] root;
   } sqrt_rsp_type;

   // Taylor series constants for the elaboration-time trig table
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SIN_DIV [0:6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};
   localparam logic [63:0] COS_DIV [0:6] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                              64'd90, 64'd132, 64'd182};

   typedef logic [CIRCLE_SEGMENTS:0][TRIG_W-1:0] trig_tab_type;

   function automatic trig_tab_type trig_table(input logic want_sin);
      trig_tab_type             tab;
      logic [63:0]              q, r, a, a2, tc, ts, sub, c, s;
      logic signed [TRIG_W-1:0] cv, sv, cs, sn;
      for (int i = 0; i <= CIRCLE_SEGMENTS; i++) begin
         q  = 64'(4 * i) / CIRCLE_SEGMENTS;
         r  = 64'(4 * i) - q * 64'(CIRCLE_SEGMENTS);
         a  = HALF_PI_Q30 * r / CIRCLE_SEGMENTS;
         a2 = (a * a) >> 30;
         tc = Q30_ONE;
         ts = Q30_ONE;
         for (int k = 6; k >= 0; k--) begin
            sub = ((a2 * ts) >> 30) / SIN_DIV[k];
            ts  = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
            sub = ((a2 * tc) >> 30) / COS_DIV[k];
            tc  = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
         end
         c  = (tc + (64'd1 << (29 - TRIG_FRACTION_BITS))) >> (30 - TRIG_FRACTION_BITS);
         s  = (((a * ts) >> 30) + (64'd1 << (29 - TRIG_FRACTION_BITS)))
              >> (30 - TRIG_FRACTION_BITS);
         cv = TRIG_W'(c);
         sv = TRIG_W'(s);
         case (q[1:0])
            2'd0: begin
               cs = cv;  sn = sv;
            end
            2'd1: begin
               cs = -sv; sn = cv;
            end
            2'd2: begin
               cs = -cv; sn = -sv;
            end
            default: begin
               cs = sv;  sn = -cv;
            end
         endcase
         tab[i] = want_sin ? sn : cs;
      end
      return tab;
   endfunction

   localparam trig_tab_type COS_TAB = trig_table(1'b0);
   localparam trig_tab_type SIN_TAB = trig_table(1'b1);

endpackage

// ===== design/laser_vector_shape_generator_core.sv =====
// Laser vector shape generator. A start command (circle of 36 chords,
// rectangle, or line) latches a shape and emits nothing; each later tick
// emits one galvo point with its beam bit and dwell, first travelling dark
// to the first vertex and then lit along every edge, shape_done flagging the
// last point. Items go through a two-entry queue into a sequencer built
// around one shared radix-2 divider and one shared integer root unit. A tick
// inside a segment waits on the two divisions for x and y; a tick that ends a
// segment adds the next segment's setup (two roots and two divisions), plus a
// vertex check per skipped vertex. A start command runs the first segment's
// setup, or only the vertex checks when the shape has no points. The queue
// keeps taking items while the sequencer works, until it is full, and the
// result register holds one finished point while the next is computed.
// Registers at byte address 0 (max_step_length, reset 100, 0 acts as 1) and
// 4 (dwell_per_unit, reset 2) should be written only while the block is idle.
module laser_vector_shape_generator_core import lvsg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pos_x[15:0], pos_y[31:16], param_a[47:32], param_b[63:48]
   input  logic [1:0]  req_tuser,   // command[1:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // point_x[15:0], point_y[31:16], dwell_us[45:32], zero
   output logic [0:0]  rsp_tuser,   // beam_on[0]
   output logic        rsp_tlast,   // shape_done
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [MSL_W-1:0] max_step_ff;
   logic [DPU_W-1:0] dwell_unit_ff;
   cfg_type          cfg;
   item_type         q_item;
   logic             q_valid, q_pop;
   res_type          res;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes land on the access cycle of the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff   <= MSL_RESET;
         dwell_unit_ff <= DPU_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_MAX_STEP_LENGTH: max_step_ff   <= csr_pwdata[MSL_W-1:0];
            REG_DWELL_PER_UNIT:  dwell_unit_ff <= csr_pwdata[DPU_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MAX_STEP_LENGTH: csr_prdata = {{(32-MSL_W){1'b0}}, max_step_ff};
         REG_DWELL_PER_UNIT:  csr_prdata = {{(32-DPU_W){1'b0}}, dwell_unit_ff};
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.max_step   = max_step_ff;
   assign cfg.dwell_unit = dwell_unit_ff;

   lvsg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_item     (q_item),
      .q_valid    (q_valid),
      .q_pop      (q_pop)
   );

   lvsg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_item    (q_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .res       (res),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready)
   );

   // result packing, first field in the low bits
   assign rsp_tdata = {2'b00, res.dwell_us, res.point_y, res.point_x};
   assign rsp_tuser = res.beam_on;
   assign rsp_tlast = res.shape_done;

endmodule

// ===== design/lvsg_front.sv =====
`include "laser_vector_shape_generator_core_assert.svh"
module lvsg_front import lvsg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pos_x, pos_y, param_a, param_b
   input  logic [1:0]  req_tuser,   // command
   output item_type    q_item,
   output logic        q_valid,
   input  logic        q_pop
);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   item_type            item_in;
   logic                push;

   always_comb begin
      item_in.cmd      = cmd_type'(req_tuser);
      item_in.is_start = (item_in.cmd != CMD_TICK);
      item_in.pos_x    = req_tdata[15:0];
      item_in.pos_y    = req_tdata[31:16];
      item_in.param_a  = req_tdata[47:32];
      item_in.param_b  = req_tdata[63:48];
   end

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            mem_ff[wr_ptr_ff] <= item_in;
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(q_pop);
      end
   end

   `LVSG_ASSERT(a_q_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
   `LVSG_ASSERT(a_q_pop, clock, reset, q_pop |-> (count_ff != '0), "pop of empty queue")
   `LVSG_ASSERT_NEXT(a_q_grow, clock, reset, push && !q_pop, count_ff == $past(count_ff) + 1'b1, "queue count lost a push")

endmodule

// ===== design/lvsg_div.sv =====
module lvsg_div import lvsg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_DEN_W-1:0] den_ff, rem_ff;
   logic [DIV_DEN_W:0]   rem_sh, rem_sub;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[DIV_NUM_W-1]};
      ge      = (rem_sh >= {1'b0, den_ff});
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            num_ff  <= req.num;
            den_ff  <= req.den;
            rem_ff  <= '0;
            cnt_ff  <= DIV_CNT_W'(DIV_NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            num_ff <= {num_ff[DIV_NUM_W-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = num_ff;

endmodule

// ===== design/lvsg_sqrt.sv =====
module lvsg_sqrt import lvsg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type req,
   output sqrt_rsp_type rsp
);

   localparam int REM_W = SQRT_OUT_W + 3;

   logic                  busy_ff, done_ff;
   logic [SQRT_CNT_W-1:0] cnt_ff;
   logic [SQRT_IN_W-1:0]  rad_ff;
   logic [REM_W-1:0]      rem_ff, rem_sh, trial;
   logic [SQRT_OUT_W-1:0] root_ff;
   logic                  ge;

   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], rad_ff[SQRT_IN_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      ge     = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rad_ff  <= req.rad;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= SQRT_CNT_W'(SQRT_OUT_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[SQRT_IN_W-3:0], 2'b00};
            rem_ff  <= ge ? rem_sh - trial : rem_sh;
            root_ff <= {root_ff[SQRT_OUT_W-2:0], ge};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == SQRT_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

// ===== design/lvsg_back.sv =====
`include "laser_vector_shape_generator_core_assert.svh"
module lvsg_back import lvsg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  item_type q_item,
   input  logic     q_valid,
   output logic     q_pop,
   output res_type  res,
   output logic     res_valid,
   input  logic     res_ready
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_MULX, ST_DIVX_GO, ST_DIVX, ST_MULY, ST_DIVY_GO, ST_DIVY,
      ST_CHECK, ST_TGT, ST_CMP, ST_SQ, ST_SUM, ST_ROOT_GO, ST_ROOT,
      ST_STEPS_GO, ST_STEPS, ST_DWMUL, ST_DWSQ_GO, ST_DWSQ, ST_DWDIV_GO,
      ST_DWDIV, ST_EMIT
   } state_type;

   state_type state_ff;

   // shape and segment state
   cmd_type                   shape_kind_ff;
   logic                      laser_ff;
   logic [VIDX_W-1:0]         vidx_ff;
   logic [COORD_W-1:0]        cur_x_ff, cur_y_ff;
   logic [COORD_W-1:0]        geo_x_ff, geo_y_ff, geo_a_ff, geo_b_ff;
   logic [COORD_W-1:0]        seg_sx_ff, seg_sy_ff;
   logic signed [DELTA_W-1:0] seg_dx_ff, seg_dy_ff;
   logic [STEP_W-1:0]         step_idx_ff, step_tot_ff;
   logic [DWELL_W-1:0]        step_dwell_ff;
   logic                      is_tick_ff;

   // working registers
   logic [COORD_W-1:0]        tx_ff, ty_ff, px_ff, py_ff;
   logic [DIV_NUM_W-1:0]      prod_mag_ff;
   logic                      prod_neg_ff;
   logic [2*COORD_W-1:0]      sqx_ff, sqy_ff;
   logic [D2_W-1:0]           d2_ff;
   logic [DPROD_W-1:0]        dprod_ff;
   logic [SQRT_OUT_W-1:0]     root_ff;
   logic                      res_beam_ff, res_done_ff;
   logic [DWELL_W-1:0]        res_dwell_ff;
   res_type                   out_ff;
   logic                      out_valid_ff;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   lvsg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   lvsg_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   logic [MSL_W-1:0]          len;
   logic [DPU_SQ_W-1:0]       dpu_sq;
   logic signed [DELTA_W-1:0] mul_delta, new_dx, new_dy;
   logic [DELTA_W-1:0]        mul_mag, dx_mag, dy_mag;
   logic [COORD_W-1:0]        pt_base, pt_off, pt_sum;
   logic [VIDX_W-1:0]         last_vidx, tab_idx;
   logic signed [TRIG_W-1:0]  cs, sn;
   logic [TRIG_W-1:0]         cs_mag, sn_mag;
   logic [COORD_W+TRIG_W-1:0] offx_prod, offy_prod;
   logic [COORD_W-1:0]        offx, offy, hl, hh, tgt_x, tgt_y;
   logic [DWELL_W-1:0]        dw_clamped;

   always_comb begin
      len    = (cfg.max_step == '0) ? MSL_W'(1) : cfg.max_step;
      dpu_sq = {{DPU_W{1'b0}}, cfg.dwell_unit} * {{DPU_W{1'b0}}, cfg.dwell_unit};

      // point interpolation: |delta| * step_index, divided later
      mul_delta = (state_ff == ST_MULY) ? seg_dy_ff : seg_dx_ff;
      mul_mag   = mul_delta[DELTA_W-1] ? DELTA_W'(-mul_delta) : DELTA_W'(mul_delta);
      pt_base   = (state_ff == ST_DIVY) ? seg_sy_ff : seg_sx_ff;
      pt_off    = prod_neg_ff ? (~div_rsp.quo[COORD_W-1:0] + 1'b1)
                              : div_rsp.quo[COORD_W-1:0];
      pt_sum    = pt_base + pt_off;

      dx_mag = seg_dx_ff[DELTA_W-1] ? DELTA_W'(-seg_dx_ff) : DELTA_W'(seg_dx_ff);
      dy_mag = seg_dy_ff[DELTA_W-1] ? DELTA_W'(-seg_dy_ff) : DELTA_W'(seg_dy_ff);

      unique case (shape_kind_ff)
         CMD_CIRCLE: last_vidx = VIDX_W'(CIRCLE_SEGMENTS);
         CMD_RECT:   last_vidx = VIDX_W'(4);
         default:    last_vidx = VIDX_W'(1);
      endcase

      // vertex target
      tab_idx   = (vidx_ff > VIDX_W'(CIRCLE_SEGMENTS)) ? VIDX_W'(CIRCLE_SEGMENTS) : vidx_ff;
      cs        = COS_TAB[tab_idx];
      sn        = SIN_TAB[tab_idx];
      cs_mag    = cs[TRIG_W-1] ? TRIG_W'(-cs) : TRIG_W'(cs);
      sn_mag    = sn[TRIG_W-1] ? TRIG_W'(-sn) : TRIG_W'(sn);
      offx_prod = {{TRIG_W{1'b0}}, geo_a_ff} * {{COORD_W{1'b0}}, cs_mag};
      offy_prod = {{TRIG_W{1'b0}}, geo_a_ff} * {{COORD_W{1'b0}}, sn_mag};
      offx      = offx_prod[TRIG_FRACTION_BITS +: COORD_W];
      offy      = offy_prod[TRIG_FRACTION_BITS +: COORD_W];
      if (cs[TRIG_W-1]) offx = -offx;
      if (sn[TRIG_W-1]) offy = -offy;
      hl = {1'b0, geo_a_ff[COORD_W-1:1]};
      hh = {1'b0, geo_b_ff[COORD_W-1:1]};

      unique case (shape_kind_ff)
         CMD_CIRCLE: begin
            tgt_x = geo_x_ff + offx;
            tgt_y = geo_y_ff + offy;
         end
         CMD_RECT: begin
            tgt_x = (vidx_ff == VIDX_W'(1) || vidx_ff == VIDX_W'(2)) ? geo_x_ff - hl
                                                                      : geo_x_ff + hl;
            tgt_y = (vidx_ff == VIDX_W'(2) || vidx_ff == VIDX_W'(3)) ? geo_y_ff - hh
                                                                      : geo_y_ff + hh;
         end
         default: begin
            tgt_x = (vidx_ff == '0) ? geo_x_ff : geo_a_ff;
            tgt_y = (vidx_ff == '0) ? geo_y_ff : geo_b_ff;
         end
      endcase

      new_dx = $signed({tx_ff[COORD_W-1], tx_ff}) - $signed({cur_x_ff[COORD_W-1], cur_x_ff});
      new_dy = $signed({ty_ff[COORD_W-1], ty_ff}) - $signed({cur_y_ff[COORD_W-1], cur_y_ff});

      if (div_rsp.quo == '0) begin
         dw_clamped = DWELL_W'(1);
      end else if (div_rsp.quo > DIV_NUM_W'(DWELL_MAX)) begin
         dw_clamped = DWELL_MAX;
      end else begin
         dw_clamped = div_rsp.quo[DWELL_W-1:0];
      end

      div_req.start = 1'b0;
      div_req.num   = prod_mag_ff;
      div_req.den   = step_tot_ff;
      unique case (state_ff)
         ST_DIVX_GO, ST_DIVY_GO: div_req.start = 1'b1;
         ST_STEPS_GO: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(root_ff);
            div_req.den   = DIV_DEN_W'(len);
         end
         ST_DWDIV_GO: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(root_ff);
         end
         default: ;
      endcase

      sqrt_req.start = (state_ff == ST_ROOT_GO) || (state_ff == ST_DWSQ_GO);
      sqrt_req.rad   = (state_ff == ST_DWSQ_GO) ? SQRT_IN_W'(dprod_ff) : SQRT_IN_W'(d2_ff);
   end

   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign res       = out_ff;
   assign res_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         shape_kind_ff <= SHAPE_IDLE;
         laser_ff      <= 1'b0;
         vidx_ff       <= '0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         step_idx_ff   <= '0;
         step_tot_ff   <= '0;
         step_dwell_ff <= DWELL_W'(1);
         is_tick_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         // the emit state owns the valid flag while it runs
         if (res_ready && state_ff != ST_EMIT) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  if (q_item.is_start) begin
                     shape_kind_ff <= q_item.cmd;
                     geo_x_ff      <= q_item.pos_x;
                     geo_y_ff      <= q_item.pos_y;
                     geo_a_ff      <= q_item.param_a;
                     geo_b_ff      <= q_item.param_b;
                     vidx_ff       <= '0;
                     laser_ff      <= 1'b0;
                     is_tick_ff    <= 1'b0;
                     state_ff      <= ST_CHECK;
                  end else if (shape_kind_ff != SHAPE_IDLE) begin
                     step_idx_ff <= step_idx_ff + 1'b1;
                     is_tick_ff  <= 1'b1;
                     state_ff    <= ST_MULX;
                  end
               end
            end
            ST_MULX, ST_MULY: begin
               prod_mag_ff <= {{(DIV_NUM_W-DELTA_W){1'b0}}, mul_mag}
                              * {{(DIV_NUM_W-STEP_W){1'b0}}, step_idx_ff};
               prod_neg_ff <= mul_delta[DELTA_W-1];
               state_ff    <= (state_ff == ST_MULX) ? ST_DIVX_GO : ST_DIVY_GO;
            end
            ST_DIVX_GO: state_ff <= ST_DIVX;
            ST_DIVY_GO: state_ff <= ST_DIVY;
            ST_DIVX: begin
               if (div_rsp.done) begin
                  px_ff    <= pt_sum;
                  state_ff <= ST_MULY;
               end
            end
            ST_DIVY: begin
               if (div_rsp.done) begin
                  py_ff        <= pt_sum;
                  cur_x_ff     <= px_ff;
                  cur_y_ff     <= pt_sum;
                  res_beam_ff  <= laser_ff;
                  res_dwell_ff <= step_dwell_ff;
                  res_done_ff  <= 1'b0;
                  if (step_idx_ff >= step_tot_ff) begin
                     vidx_ff  <= vidx_ff + 1'b1;
                     state_ff <= ST_CHECK;
                  end else begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_CHECK: begin
               if (vidx_ff > last_vidx) begin
                  shape_kind_ff <= SHAPE_IDLE;
                  laser_ff      <= 1'b0;
                  res_done_ff   <= 1'b1;
                  state_ff      <= is_tick_ff ? ST_EMIT : ST_IDLE;
               end else begin
                  state_ff <= ST_TGT;
               end
            end
            ST_TGT: begin
               tx_ff    <= tgt_x;
               ty_ff    <= tgt_y;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (tx_ff == cur_x_ff && ty_ff == cur_y_ff) begin
                  vidx_ff  <= vidx_ff + 1'b1;
                  state_ff <= ST_CHECK;
               end else begin
                  seg_sx_ff <= cur_x_ff;
                  seg_sy_ff <= cur_y_ff;
                  seg_dx_ff <= new_dx;
                  seg_dy_ff <= new_dy;
                  state_ff  <= ST_SQ;
               end
            end
            ST_SQ: begin
               sqx_ff   <= dx_mag[COORD_W-1:0] * dx_mag[COORD_W-1:0];
               sqy_ff   <= dy_mag[COORD_W-1:0] * dy_mag[COORD_W-1:0];
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               d2_ff    <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
               state_ff <= ST_ROOT_GO;
            end
            ST_ROOT_GO: state_ff <= ST_ROOT;
            ST_ROOT: begin
               if (sqrt_rsp.done) begin
                  root_ff  <= sqrt_rsp.root;
                  state_ff <= ST_STEPS_GO;
               end
            end
            ST_STEPS_GO: state_ff <= ST_STEPS;
            ST_STEPS: begin
               if (div_rsp.done) begin
                  step_tot_ff <= div_rsp.quo[STEP_W-1:0] + 1'b1;
                  step_idx_ff <= '0;
                  state_ff    <= ST_DWMUL;
               end
            end
            ST_DWMUL: begin
               dprod_ff <= {{DPU_SQ_W{1'b0}}, d2_ff} * {{D2_W{1'b0}}, dpu_sq};
               state_ff <= ST_DWSQ_GO;
            end
            ST_DWSQ_GO: state_ff <= ST_DWSQ;
            ST_DWSQ: begin
               if (sqrt_rsp.done) begin
                  root_ff  <= sqrt_rsp.root;
                  state_ff <= ST_DWDIV_GO;
               end
            end
            ST_DWDIV_GO: state_ff <= ST_DWDIV;
            ST_DWDIV: begin
               if (div_rsp.done) begin
                  step_dwell_ff <= dw_clamped;
                  laser_ff      <= (vidx_ff != '0);
                  state_ff      <= is_tick_ff ? ST_EMIT : ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (!out_valid_ff || res_ready) begin
                  out_ff.point_x    <= px_ff;
                  out_ff.point_y    <= py_ff;
                  out_ff.beam_on    <= res_beam_ff;
                  out_ff.dwell_us   <= res_dwell_ff;
                  out_ff.shape_done <= res_done_ff;
                  out_valid_ff      <= 1'b1;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `LVSG_ASSERT(a_div_free, clock, reset, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
   `LVSG_ASSERT(a_sqrt_free, clock, reset, sqrt_req.start |-> !sqrt_rsp.busy, "root unit restarted while busy")
   `LVSG_ASSERT(a_laser_idle, clock, reset, (shape_kind_ff == SHAPE_IDLE) |-> !laser_ff, "laser lit with no shape")
   `LVSG_ASSERT(a_steps_set, clock, reset, (state_ff == ST_IDLE && shape_kind_ff != SHAPE_IDLE) |-> (step_tot_ff != '0), "active shape with zero steps")

endmodule

// ===== sim/laser_vector_shape_generator_core_test.sv =====
`timescale 1ns / 100ps

module laser_vector_shape_generator_core_test;
   import lvsg_pkg::*;

   // One galvo point as the block should report it
   typedef struct {
      logic [15:0] px;
      logic [15:0] py;
      logic        lit;
      logic [13:0] dwell;
      logic        done;
   } galvo_point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = CMD_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   laser_vector_shape_generator_core uut (.*);

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the shape sequencer
   // ---------------------------------------------------------------------
   int unsigned   step_len = 100;      // max_step_length
   int unsigned   dwell_unit = 2;      // dwell_per_unit
   logic [15:0]   pos_cur_x = '0, pos_cur_y = '0;
   logic          beam_lit = 1'b0;
   cmd_type       active_shape = SHAPE_IDLE;
   int unsigned   vertex_no = 0;
   logic [15:0]   geo [4];
   logic [15:0]   seg_x0, seg_y0;
   longint        seg_dx, seg_dy;
   longint        step_no = 0, step_cnt = 0;
   int unsigned   step_dwell = 1;
   int            cos_q15 [0:CIRCLE_SEGMENTS];
   int            sin_q15 [0:CIRCLE_SEGMENTS];

   galvo_point_type expected_points [$];
   int            mismatches = 0;
   int            points_seen = 0;
   int            items_sent = 0;
   int            shapes_sent = 0;
   int            tx_idle_pct = 0, rx_idle_pct = 0;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Quadrant-reduced Taylor series in Q30, rounded half up to Q15
   task automatic build_trig();
      longint unsigned one_q30 = 64'd1073741824, half_pi = 64'd1686629713;
      longint unsigned q, r, a, a2, tc, ts, sub;
      int c, s;
      for (int i = 0; i <= CIRCLE_SEGMENTS; i++) begin
         q  = (4 * i) / CIRCLE_SEGMENTS;
         r  = 4 * i - q * CIRCLE_SEGMENTS;
         a  = half_pi * r / CIRCLE_SEGMENTS;
         a2 = (a * a) >> 30;
         tc = one_q30;
         ts = one_q30;
         for (int k = 7; k >= 1; k--) begin
            sub = ((a2 * ts) >> 30) / ((2 * k) * (2 * k + 1));
            ts  = sub > one_q30 ? 0 : one_q30 - sub;
            sub = ((a2 * tc) >> 30) / ((2 * k - 1) * (2 * k));
            tc  = sub > one_q30 ? 0 : one_q30 - sub;
         end
         c = int'((tc + (64'd1 << 14)) >> 15);
         s = int'((((a * ts) >> 30) + (64'd1 << 14)) >> 15);
         case (q[1:0])
            2'd0: begin cos_q15[i] = c;  sin_q15[i] = s;  end
            2'd1: begin cos_q15[i] = -s; sin_q15[i] = c;  end
            2'd2: begin cos_q15[i] = -c; sin_q15[i] = -s; end
            default: begin cos_q15[i] = s; sin_q15[i] = -c; end
         endcase
      end
   endtask

   function automatic logic [15:0] radial_offset(input logic [15:0] radius, input int f);
      longint unsigned m;
      m = (longint'(radius) * (f < 0 ? -f : f)) >> 15;
      return f < 0 ? 16'(-m) : 16'(m);
   endfunction

   function automatic int unsigned final_vertex();
      case (active_shape)
         CMD_CIRCLE: return CIRCLE_SEGMENTS;
         CMD_RECT:   return 4;
         default:    return 1;
      endcase
   endfunction

   function automatic void corner_of(input int unsigned k, output logic [15:0] tx, ty);
      logic [15:0] hl, hh;
      hl = geo[2] >> 1;
      hh = geo[3] >> 1;
      case (active_shape)
         CMD_CIRCLE: begin
            tx = geo[0] + radial_offset(geo[2], cos_q15[k]);
            ty = geo[1] + radial_offset(geo[2], sin_q15[k]);
         end
         CMD_RECT: begin
            tx = (k == 1 || k == 2) ? geo[0] - hl : geo[0] + hl;
            ty = (k == 2 || k == 3) ? geo[1] - hh : geo[1] + hh;
         end
         default: begin
            tx = k == 0 ? geo[0] : geo[2];
            ty = k == 0 ? geo[1] : geo[3];
         end
      endcase
   endfunction

   // Set up the next segment that actually moves; returns 0 when the shape is over
   function automatic bit next_segment();
      logic [15:0]     tx, ty;
      longint unsigned d2, steps, dw;
      while (vertex_no <= final_vertex()) begin
         corner_of(vertex_no, tx, ty);
         if (tx != pos_cur_x || ty != pos_cur_y) begin
            seg_dx = longint'($signed(tx)) - longint'($signed(pos_cur_x));
            seg_dy = longint'($signed(ty)) - longint'($signed(pos_cur_y));
            d2     = seg_dx * seg_dx + seg_dy * seg_dy;
            steps  = int_sqrt(d2) / (step_len == 0 ? 1 : step_len) + 1;
            dw     = int_sqrt(longint'(dwell_unit * dwell_unit) * d2) / steps;
            if (dw == 0) dw = 1;
            if (dw > 16383) dw = 16383;
            seg_x0     = pos_cur_x;
            seg_y0     = pos_cur_y;
            step_cnt   = steps;
            step_no    = 0;
            step_dwell = 32'(dw);
            beam_lit   = vertex_no > 0;
            return 1'b1;
         end
         vertex_no++;
      end
      active_shape = SHAPE_IDLE;
      beam_lit = 1'b0;
      return 1'b0;
   endfunction

   task automatic predict_item(input cmd_type cmd, input logic [63:0] fields);
      galvo_point_type p;
      if (cmd != CMD_TICK) begin
         active_shape = cmd;
         for (int i = 0; i < 4; i++) geo[i] = fields[16*i +: 16];
         vertex_no = 0;
         beam_lit = 1'b0;
         void'(next_segment());
         return;
      end
      if (active_shape == SHAPE_IDLE) return;
      step_no++;
      p.px    = seg_x0 + 16'(seg_dx * step_no / step_cnt);
      p.py    = seg_y0 + 16'(seg_dy * step_no / step_cnt);
      p.lit   = beam_lit;
      p.dwell = 14'(step_dwell);
      p.done  = 1'b0;
      pos_cur_x = p.px;
      pos_cur_y = p.py;
      if (step_no >= step_cnt) begin
         vertex_no++;
         if (!next_segment()) p.done = 1'b1;
      end
      expected_points.push_back(p);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall, compare each transfer with the oldest point
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= $urandom_range(99) >= rx_idle_pct;
   end

   always @(posedge clock) begin
      galvo_point_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         points_seen++;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected point x=%h y=%h", $realtime,
                        rsp_tdata[15:0], rsp_tdata[31:16]);
         end else begin
            e = expected_points.pop_front();
            if (rsp_tdata[15:0] !== e.px || rsp_tdata[31:16] !== e.py ||
                rsp_tdata[45:32] !== e.dwell || rsp_tuser[0] !== e.lit ||
                rsp_tlast !== e.done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: point mismatch exp x=%h y=%h lit=%b dw=%0d done=%b, got x=%h y=%h lit=%b dw=%0d done=%b",
                           $realtime, e.px, e.py, e.lit, e.dwell, e.done,
                           rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser[0],
                           rsp_tdata[45:32], rsp_tlast);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------------
   task automatic send_item(input cmd_type cmd, input logic [15:0] x, y, a, b);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {b, a, y, x};
      do @(posedge clock); while (!req_tready);
      // transfer taken at this edge
      predict_item(cmd, {b, a, y, x});
      items_sent++;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Start a shape and tick it until done, or abandon it after tick_cap ticks
   task automatic run_shape(input cmd_type cmd, input logic [15:0] x, y, a, b,
                            input int tick_cap);
      int n;
      n = 0;
      send_item(cmd, x, y, a, b);
      shapes_sent++;
      while (active_shape != SHAPE_IDLE && n < tick_cap) begin
         send_item(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
         n++;
      end
   endtask

   // Register writes only with the block drained; queued starts may still be settling
   task automatic write_reg(input logic idx, input int unsigned value);
      req_tvalid <= 1'b0;
      wait (expected_points.size() == 0);
      repeat (1000) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_MAX_STEP_LENGTH) step_len = value & 32'h3FF;
      else dwell_unit = value & 32'hF;
   endtask

   task automatic set_config(input int unsigned len, input int unsigned dpu);
      write_reg(REG_MAX_STEP_LENGTH, len);
      write_reg(REG_DWELL_PER_UNIT, dpu);
   endtask

   // Extremes, empty shapes, skipped vertices, restarts and idle ticks
   task automatic test_directed();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_item(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // idle tick
      run_shape(CMD_LINE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4);   // empty line
      run_shape(CMD_RECT, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 4);   // empty rectangle
      run_shape(CMD_CIRCLE, 16'h0000, 16'h0000, 16'h0003, 16'h0000, 40); // duplicate vertices
      set_config(1023, 15);
      run_shape(CMD_LINE, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 5);    // abandoned
      run_shape(CMD_RECT, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 6);
      send_item(CMD_TICK, '0, '0, '0, '0);
      set_config(0, 0);                                                  // length 0 acts as 1
      run_shape(CMD_LINE, pos_cur_x, pos_cur_y, pos_cur_x + 16'd3, pos_cur_y, 8);
   endtask

   // budget: items still allowed in the current test
   task automatic random_shape(input int budget);
      cmd_type     cmd;
      logic [15:0] x, y, a, b;
      int          span;
      int          cap;
      cmd  = cmd_type'($urandom_range(1, 3));
      span = 4 * (step_len == 0 ? 1 : step_len) + 8;
      if ($urandom_range(7) == 0) begin
         {x, y, a, b} = {$urandom, $urandom};
      end else begin
         x = pos_cur_x + 16'($urandom_range(0, 2 * span) - span);
         y = pos_cur_y + 16'($urandom_range(0, 2 * span) - span);
         a = cmd == CMD_LINE ? x + 16'($urandom_range(0, 2 * span) - span)
                             : 16'($urandom_range(0, 2 * span));
         b = cmd == CMD_LINE ? y + 16'($urandom_range(0, 2 * span) - span)
                             : 16'($urandom_range(0, 2 * span));
      end
      cap = $urandom_range(9) == 0 ? $urandom_range(0, 8) : 70;
      if (cap > budget - 1) cap = budget - 1;
      if (cap < 0) cap = 0;
      run_shape(cmd, x, y, a, b, cap);
      if ($urandom_range(4) == 0) send_item(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic test_random(input int tx_pct, input int rx_pct,
                              input int unsigned len, input int unsigned dpu,
                              input int n_items);
      int stop_at;
      set_config(len, dpu);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) random_shape(stop_at - items_sent);
   endtask

   initial begin
      build_trig();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(32, 71, 100, 2, 140);
      test_random(32, 71, 1, 15, 140);
      test_random(71, 32, 1023, 0, 140);
      test_random(71, 32, 37, 9, 140);
      test_random(0, 0, 5, 1, 140);
      test_random(0, 0, 250, 15, 140);
      req_tvalid <= 1'b0;
      wait (expected_points.size() == 0);
      repeat (400) @(posedge clock);
      $display("Sent %0d items (%0d shapes), checked %0d points over several step/dwell settings.",
               items_sent, shapes_sent, points_seen);
      if (mismatches == 0 && expected_points.size() == 0)
         $display("laser_vector_shape_generator_core verification clean");
      else
         $display("laser_vector_shape_generator_core verification failed");
      $finish;
   end

   initial begin
      #200ms;
      $display("laser_vector_shape_generator_core verification failed");
      $finish;
   end

endmodule

// ===== laser_vector_shape_generator_core.f =====
+incdir+design
design/lvsg_pkg.sv
design/lvsg_front.sv
design/lvsg_div.sv
design/lvsg_sqrt.sv
design/lvsg_back.sv
design/laser_vector_shape_generator_core.sv
sim/laser_vector_shape_generator_core_test.sv
